// ===== sv/lsga_pkg.sv =====
`timescale 1ns / 1ps

package lsga_pkg;

    // Field widths of the command and result beats
    localparam int IDX_W        = 4;
    localparam int BYTES_W      = 12;
    localparam int DEST_W       = 4;
    localparam int SERVED_W     = 32;
    localparam int OPCODE_W     = 2;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 24;

    // Default table size and the reset value of the active slave count
    localparam int MAX_SLAVES_DEF    = 14;
    localparam int ACTIVE_RESET      = 14;

    // Operation codes carried in tuser
    typedef enum logic [OPCODE_W-1:0] {
        OP_CLR_REQ = 2'd0,
        OP_RECORD  = 2'd1,
        OP_GRANT   = 2'd2,
        OP_CLR_ALL = 2'd3
    } t_opcode;

    // Running best candidate passed from cell to cell during a scan
    typedef struct packed {
        logic                found;
        logic [SERVED_W-1:0] served;
        logic [IDX_W-1:0]    idx;     // zero-based cell number
        logic [BYTES_W-1:0]  size;
        logic [DEST_W-1:0]   dest;
    } t_cand;

    // Table update broadcast to all cells
    typedef struct packed {
        logic               clr_req;
        logic               clr_tot;
        logic               rec_en;
        logic               upd_en;
        logic [IDX_W-1:0]   sel;      // zero-based cell number
        logic [BYTES_W-1:0] bytes;
        logic [DEST_W-1:0]  dest;
    } t_cell_cmd;

endpackage

// ===== sv/lsga_cell.sv =====
`timescale 1ns / 1ps

module lsga_cell import lsga_pkg::*; #(
    parameter int CELL_ID = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  logic      i_tok,
    input  t_cand     i_cand,
    output logic      o_tok,
    output t_cand     o_cand,
    output logic      o_pending
);

    logic                r_flag;
    logic [SERVED_W-1:0] r_served;
    logic [BYTES_W-1:0]  r_size;
    logic [DEST_W-1:0]   r_dest;
    logic                r_tok;
    t_cand               r_cand;

    logic                w_hit;
    logic [SERVED_W:0]   w_sum;
    logic                w_take_own;
    t_cand               w_own;

    assign w_hit = (i_cmd.sel == IDX_W'(CELL_ID));

    // saturating total update
    assign w_sum = {1'b0, r_served} + (SERVED_W + 1)'(r_size);

    // table entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag   <= 1'b0;
            r_served <= '0;
        end else begin
            if (i_cmd.clr_req) begin
                r_flag <= 1'b0;
            end
            if (i_cmd.clr_tot) begin
                r_served <= '0;
            end
            if (i_cmd.rec_en && w_hit) begin
                r_flag <= 1'b1;
            end
            if (i_cmd.upd_en && w_hit) begin
                r_flag   <= 1'b0;
                r_served <= w_sum[SERVED_W] ? '1 : w_sum[SERVED_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rec_en && w_hit) begin
            r_size <= i_cmd.bytes;
            r_dest <= i_cmd.dest;
        end
    end

    // scan step: keep the incoming candidate unless this entry pends and is strictly less served, or none was found yet
    always_comb begin
        w_own.found  = 1'b1;
        w_own.served = r_served;
        w_own.idx    = IDX_W'(CELL_ID);
        w_own.size   = r_size;
        w_own.dest   = r_dest;
    end

    assign w_take_own = r_flag && (!i_cand.found || (r_served < i_cand.served));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_cand <= w_take_own ? w_own : i_cand;
        end
    end

    assign o_tok     = r_tok;
    assign o_cand    = r_cand;
    assign o_pending = r_flag;

endmodule

// ===== sv/least_served_grant_arbiter_core.sv =====
`timescale 1ns / 1ps
// Least-served-first grant arbiter.
// Command beats arrive on the s_axis channel: tuser holds the operation
// (clear requests, record, grant, clear requests and totals), tdata the
// slave index, byte count and destination. Every command beat yields exactly
// one result beat on the m_axis channel.
// Clear and record commands finish in the cycle they are accepted; their
// result is registered and shows in the cycle after. A grant walks a token
// down the row of MAX_SLAVES slave cells, one cell per cycle, each cell
// comparing its total against the best so far; once the token leaves the
// last cell the winner is loaded into the output register when it is free,
// and the block returns to idle to take the next command.
// A write on the configuration port sets the number of active slaves
// (saturated to MAX_SLAVES) and drops all requests and totals; the user
// must do it only while the block is idle, the block itself does not enforce it.
// Reset drops all requests, zeroes all totals and sets the active count to 14
// (or MAX_SLAVES if smaller). While m_axis is stalled the result holds in the
// output register; one more command may be accepted if the output frees in
// the same cycle, otherwise s_axis tready stays low.

module least_served_grant_arbiter_core import lsga_pkg::*; #(
    parameter int MAX_SLAVES = MAX_SLAVES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [IDX_W-1:0]     i_cfg_wdata,      // active_slaves
    // command channel
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // slave_index[3:0], request_bytes[15:4],
                                                   // request_dest[19:16], zero[23:20]
    input  logic [OPCODE_W-1:0]  i_s_axis_tuser,   // opcode[1:0]
    // result channel
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata    // granted[0], grant_slave[4:1],
                                                   // grant_bytes[16:5], grant_dest[20:17],
                                                   // any_pending[21], bad_index[22], zero[23]
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_active;
    logic               r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;

    t_opcode            w_op;
    logic [IDX_W-1:0]   w_idx;
    logic [BYTES_W-1:0] w_bytes;
    logic [DEST_W-1:0]  w_dest;
    logic               w_out_free;
    logic               w_accept;
    logic               w_rec_ok;
    logic               w_bad;
    logic               w_load;
    logic               w_finish;
    t_cell_cmd          w_cmd;

    logic [MAX_SLAVES-1:0] w_tok;
    logic [MAX_SLAVES-1:0] w_pend;
    logic [MAX_SLAVES-1:0] w_pend_left;
    t_cand                 w_cand [MAX_SLAVES];
    t_cand                 w_cand_in0;
    t_cand                 w_win;

    // beat fields
    assign w_op    = t_opcode'(i_s_axis_tuser);
    assign w_idx   = i_s_axis_tdata[IDX_W-1:0];
    assign w_bytes = i_s_axis_tdata[IDX_W +: BYTES_W];
    assign w_dest  = i_s_axis_tdata[IDX_W+BYTES_W +: DEST_W];

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_rec_ok = (w_idx != '0) && (w_idx <= r_active);
    assign w_bad    = !w_rec_ok;

    assign w_win    = w_cand[MAX_SLAVES-1];
    assign w_finish = (r_state == ST_DONE) && w_out_free;

    // broadcast table command
    always_comb begin
        w_cmd.clr_req = i_cfg_we;
        w_cmd.clr_tot = i_cfg_we;
        w_cmd.rec_en  = 1'b0;
        w_cmd.upd_en  = 1'b0;
        w_cmd.sel     = w_idx - IDX_W'(1);
        w_cmd.bytes   = w_bytes;
        w_cmd.dest    = w_dest;
        if (w_finish) begin
            w_cmd.upd_en = w_win.found;
            w_cmd.sel    = w_win.idx;
        end else if (w_accept) begin
            unique case (w_op)
                OP_CLR_REQ: w_cmd.clr_req = 1'b1;
                OP_CLR_ALL: begin
                    w_cmd.clr_req = 1'b1;
                    w_cmd.clr_tot = 1'b1;
                end
                OP_RECORD:  w_cmd.rec_en = w_rec_ok && (w_bytes != '0);
                OP_GRANT:   w_cmd.rec_en = 1'b0;
                default:    w_cmd.rec_en = 1'b0;
            endcase
        end
    end

    // row of slave cells
    always_comb begin
        w_cand_in0        = '0;
        w_cand_in0.found  = 1'b0;
    end

    genvar gk;
    generate
        for (gk = 0; gk < MAX_SLAVES; gk++) begin : g_cell
            if (gk == 0) begin : g_first
                lsga_cell #(.CELL_ID(gk)) u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_cmd     (w_cmd),
                    .i_tok     (w_accept && (w_op == OP_GRANT)),
                    .i_cand    (w_cand_in0),
                    .o_tok     (w_tok[gk]),
                    .o_cand    (w_cand[gk]),
                    .o_pending (w_pend[gk])
                );
            end else begin : g_next
                lsga_cell #(.CELL_ID(gk)) u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_cmd     (w_cmd),
                    .i_tok     (w_tok[gk-1]),
                    .i_cand    (w_cand[gk-1]),
                    .o_tok     (w_tok[gk]),
                    .o_cand    (w_cand[gk]),
                    .o_pending (w_pend[gk])
                );
            end
            assign w_pend_left[gk] = w_pend[gk] &&
                                     !(w_win.found && (w_win.idx == IDX_W'(gk)));
        end
    endgenerate

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept && (w_op == OP_GRANT)) n_state = ST_SCAN;
            ST_SCAN: if (w_tok[MAX_SLAVES-1]) n_state = ST_DONE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // result word
    always_comb begin
        n_out_data = '0;
        w_load     = 1'b0;
        if (w_finish) begin
            w_load = 1'b1;
            if (w_win.found) begin
                n_out_data[0]     = 1'b1;
                n_out_data[4:1]   = w_win.idx + IDX_W'(1);
                n_out_data[16:5]  = w_win.size;
                n_out_data[20:17] = w_win.dest;
            end
            n_out_data[21] = |w_pend_left;
        end else if (w_accept) begin
            unique case (w_op)
                OP_CLR_REQ, OP_CLR_ALL: begin
                    w_load         = 1'b1;
                    n_out_data[21] = 1'b0;
                end
                OP_RECORD: begin
                    w_load         = 1'b1;
                    n_out_data[21] = (|w_pend) || (w_rec_ok && (w_bytes != '0));
                    n_out_data[22] = w_bad;
                end
                OP_GRANT:  w_load = 1'b0;
                default:   w_load = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= (MAX_SLAVES < ACTIVE_RESET) ? IDX_W'(MAX_SLAVES)
                                                       : IDX_W'(ACTIVE_RESET);
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_active <= (i_cfg_wdata > IDX_W'(MAX_SLAVES)) ? IDX_W'(MAX_SLAVES)
                                                               : i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // at most one scan token in the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one scan token in the cell row");

    // a configuration write leaves nothing pending
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (w_pend == '0))
        else $error("requests survive a configuration write");

    // a grant carries a nonzero byte count
    a_grant_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[0]) |-> (o_m_axis_tdata[16:5] != '0))
        else $error("grant with zero bytes");

    // no commands taken while a scan runs
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tok != '0) |-> !o_s_axis_tready)
        else $error("command accepted during a scan");

endmodule

// ===== tb/least_served_grant_arbiter_core_tb.sv =====
`timescale 1ns / 1ps

module least_served_grant_arbiter_core_tb;
    import lsga_pkg::*;

    // One command beat as the sender sees it
    typedef struct {
        t_opcode            op;
        logic [IDX_W-1:0]   idx;
        logic [BYTES_W-1:0] bytes;
        logic [DEST_W-1:0]  dest;
    } t_arb_cmd;

    // Result beat layout, msb first: pad, bad_index, any_pending, dest, bytes, slave, granted
    typedef struct packed {
        logic               pad;
        logic               bad_index;
        logic               any_pending;
        logic [DEST_W-1:0]  grant_dest;
        logic [BYTES_W-1:0] grant_bytes;
        logic [IDX_W-1:0]   grant_slave;
        logic               granted;
    } t_grant_beat;

    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 155;
    localparam int SCAN_CYCLES  = MAX_SLAVES_DEF + 6;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [IDX_W-1:0]     i_cfg_wdata = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic [OPCODE_W-1:0]  i_s_axis_tuser = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;

    least_served_grant_arbiter_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the arbitration table
    logic [MAX_SLAVES_DEF-1:0] pend_flag;
    logic [SERVED_W-1:0]       served_total [MAX_SLAVES_DEF];
    logic [BYTES_W-1:0]        pend_size [MAX_SLAVES_DEF];
    logic [DEST_W-1:0]         pend_dest [MAX_SLAVES_DEF];
    int                        live_slaves;

    t_arb_cmd    cmd_backlog[$];
    t_grant_beat expected_results[$];
    int          cmds_queued = 0;
    int          cmds_taken_cnt = 0;
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          sink_stall_pct = 0;
    bit          cmd_taken = 1'b0;

    function automatic void drop_all_requests();
        pend_flag = '0;
    endfunction

    function automatic void zero_totals();
        for (int i = 0; i < MAX_SLAVES_DEF; i++) begin
            served_total[i] = '0;
        end
    endfunction

    // Register write: saturate the count, drop requests and totals
    function automatic void apply_slave_count(logic [IDX_W-1:0] v);
        live_slaves = (v > MAX_SLAVES_DEF) ? MAX_SLAVES_DEF : int'(v);
        drop_all_requests();
        zero_totals();
    endfunction

    // Apply one command to the shadow table and return the result beat it yields
    function automatic t_grant_beat arbitrate(t_arb_cmd c);
        t_grant_beat r;
        int          best;
        logic [32:0] sum;
        r = '0;
        best = -1;
        case (c.op)
            OP_CLR_REQ: begin
                drop_all_requests();
            end
            OP_CLR_ALL: begin
                drop_all_requests();
                zero_totals();
            end
            OP_RECORD: begin
                if (c.idx == 0 || int'(c.idx) > live_slaves) begin
                    r.bad_index = 1'b1;
                end else if (c.bytes != 0) begin
                    pend_flag[c.idx-1] = 1'b1;
                    pend_size[c.idx-1] = c.bytes;
                    pend_dest[c.idx-1] = c.dest;
                end
            end
            default: begin
                // fewest bytes served wins, strict compare keeps the lowest index on ties
                for (int i = 0; i < live_slaves; i++) begin
                    if (pend_flag[i] && (best < 0 || served_total[i] < served_total[best]))
                        best = i;
                end
                if (best >= 0) begin
                    pend_flag[best] = 1'b0;
                    sum = {1'b0, served_total[best]} + 33'(pend_size[best]);
                    served_total[best] = sum[32] ? '1 : sum[31:0];
                    r.granted     = 1'b1;
                    r.grant_slave = IDX_W'(best + 1);
                    r.grant_bytes = pend_size[best];
                    r.grant_dest  = pend_dest[best];
                end
            end
        endcase
        r.any_pending = |pend_flag;
        return r;
    endfunction

    function automatic void report_mismatch(string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function automatic void check_field(string name, int want, int got, int beat_no);
        if (want != got)
            report_mismatch($sformatf("result %0d %s expected %0d got %0d",
                                      beat_no, name, want, got));
    endfunction

    function automatic void push_cmd(t_opcode op, int idx, int bytes, int dest);
        t_arb_cmd c;
        c.op    = op;
        c.idx   = IDX_W'(idx);
        c.bytes = BYTES_W'(bytes);
        c.dest  = DEST_W'(dest);
        cmd_backlog.insert(cmd_backlog.size(), c);
        cmds_queued++;
    endfunction

    // Mostly record/grant traffic with valid slaves, sprinkled with bad records and clears
    function automatic void push_random_cmds(int count);
        int roll;
        int idx;
        int bytes;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                if (live_slaves == 0 || $urandom_range(99) < 6) begin
                    idx = ($urandom_range(1) == 0 || live_slaves == 0) ? 0 :
                          $urandom_range(15, live_slaves + 1);
                    if (live_slaves == 0)
                        idx = $urandom_range(15);
                end else begin
                    idx = $urandom_range(live_slaves, 1);
                end
                case ($urandom_range(9))
                    0:       bytes = 0;
                    1, 2:    bytes = $urandom_range(16, 1);
                    3:       bytes = 4094;
                    default: bytes = $urandom_range(4094, 1);
                endcase
                push_cmd(OP_RECORD, idx, bytes, $urandom_range(15));
            end else if (roll < 93) begin
                push_cmd(OP_GRANT, $urandom_range(15), $urandom_range(4094),
                         $urandom_range(15));
            end else if (roll < 97) begin
                push_cmd(OP_CLR_REQ, $urandom_range(15), $urandom_range(4094),
                         $urandom_range(15));
            end else begin
                push_cmd(OP_CLR_ALL, $urandom_range(15), $urandom_range(4094),
                         $urandom_range(15));
            end
        end
    endfunction

    // Command driver: next beat goes out at the falling edge once the current one is taken
    always @(negedge i_clk) begin : cmd_driver
        t_arb_cmd nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || cmd_taken) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = cmd_backlog.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {4'b0, nxt.dest, nxt.bytes, nxt.idx};
                i_s_axis_tuser  <= nxt.op;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result sink backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_m_axis_tready <= 1'b0;
        else
            i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Monitor: check result beats first, then predict the command beat taken this edge
    always @(posedge i_clk) begin : beat_monitor
        t_grant_beat got;
        t_grant_beat want;
        t_arb_cmd    c;
        int          beat_no;
        cmd_taken = 1'b0;
        if (i_rst_n) begin
            if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                beat_no = cmds_taken_cnt - expected_results.size();
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result beat %h with no command outstanding",
                                              got));
                end else begin
                    want = expected_results.pop_front();
                    check_field("granted",     want.granted,     got.granted,     beat_no);
                    check_field("grant_slave", want.grant_slave, got.grant_slave, beat_no);
                    check_field("grant_bytes", want.grant_bytes, got.grant_bytes, beat_no);
                    check_field("grant_dest",  want.grant_dest,  got.grant_dest,  beat_no);
                    check_field("any_pending", want.any_pending, got.any_pending, beat_no);
                    check_field("bad_index",   want.bad_index,   got.bad_index,   beat_no);
                    check_field("pad",         want.pad,         got.pad,         beat_no);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready === 1'b1) begin
                cmd_taken = 1'b1;
                c.op    = t_opcode'(i_s_axis_tuser);
                c.idx   = i_s_axis_tdata[3:0];
                c.bytes = i_s_axis_tdata[15:4];
                c.dest  = i_s_axis_tdata[19:16];
                expected_results.insert(expected_results.size(), arbitrate(c));
                cmds_taken_cnt++;
            end
        end
    end

    task automatic wait_drained();
        while (cmds_taken_cnt != cmds_queued || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Stimulus sequencing: directed checks, then random phases at several slave counts
    initial begin : stimulus
        int cfg_val;
        pend_flag = '0;
        for (int i = 0; i < MAX_SLAVES_DEF; i++) begin
            served_total[i] = '0;
            pend_size[i]    = '0;
            pend_dest[i]    = '0;
        end
        live_slaves = ACTIVE_RESET;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // grant on an empty table
        push_cmd(OP_GRANT, 9, 77, 3);
        // out of range records, index zero and above the active count
        push_cmd(OP_RECORD, 0, 5, 2);
        push_cmd(OP_RECORD, 15, 4094, 15);
        // zero size on a valid slave is ignored
        push_cmd(OP_RECORD, 3, 0, 6);
        push_cmd(OP_RECORD, 1, 4094, 15);
        push_cmd(OP_RECORD, 14, 1, 0);
        // re-record replaces size and destination
        push_cmd(OP_RECORD, 14, 100, 9);
        push_cmd(OP_RECORD, 7, 50, 5);
        // all totals zero: lowest index wins
        push_cmd(OP_GRANT, 0, 0, 0);
        push_cmd(OP_GRANT, 15, 4094, 15);
        push_cmd(OP_RECORD, 1, 10, 1);
        push_cmd(OP_GRANT, 0, 0, 0);
        push_cmd(OP_GRANT, 0, 0, 0);
        push_cmd(OP_GRANT, 0, 0, 0);
        push_cmd(OP_RECORD, 2, 20, 2);
        push_cmd(OP_RECORD, 5, 30, 4);
        // round clear with junk fields
        push_cmd(OP_CLR_REQ, 15, 4094, 15);
        push_cmd(OP_GRANT, 0, 0, 0);
        // least served beats lower index
        push_cmd(OP_RECORD, 1, 8, 8);
        push_cmd(OP_RECORD, 2, 8, 8);
        push_cmd(OP_GRANT, 0, 0, 0);
        // full clear while slave 1 still pends
        push_cmd(OP_CLR_ALL, 0, 4094, 15);
        push_cmd(OP_RECORD, 1, 3, 12);
        push_cmd(OP_RECORD, 9, 3, 13);
        push_cmd(OP_GRANT, 0, 0, 0);
        push_cmd(OP_GRANT, 0, 0, 0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            // grant scan may still be settling after the last beat
            repeat (SCAN_CYCLES) @(negedge i_clk);
            case (p)
                0:       cfg_val = 15;
                1:       cfg_val = 1;
                2:       cfg_val = 0;
                3:       cfg_val = 14;
                4:       cfg_val = 7;
                5:       cfg_val = 3;
                default: cfg_val = $urandom_range(15);
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= IDX_W'(cfg_val);
            apply_slave_count(IDX_W'(cfg_val));
            @(negedge i_clk);
            i_cfg_we <= 1'b0;

            case (p % 4)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 67; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 67; end
                default: begin send_idle_pct = 29; sink_stall_pct = 29; end
            endcase
            push_random_cmds(PHASE_ITEMS);
            wait_drained();
        end

        repeat (SCAN_CYCLES * 2) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (error_count == 0) begin
            $display("least_served_grant_arbiter_core_tb: PASS");
        end else begin
            $display("least_served_grant_arbiter_core_tb: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("least_served_grant_arbiter_core_tb: FAIL");
        $finish;
    end

endmodule
